@@ hdl/cau_pkg.sv @@
// Shared opcodes and default sizes for the complex arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;
  localparam int CMD_W = 3;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_CONJ = 3'd4,
    CMD_MAG  = 3'd5
  } cmd_t;
endpackage
`default_nettype wire

@@ hdl/cau_in_if.sv @@
// Input item channel: opcode and two complex operands.
`timescale 1ns / 1ps
`default_nettype none
interface cau_in_if #(parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF);
  logic                         valid;
  logic                         ready;
  logic [cau_pkg::CMD_W-1:0]    cmd;
  logic signed [DATA_WIDTH-1:0] a_re;
  logic signed [DATA_WIDTH-1:0] a_im;
  logic signed [DATA_WIDTH-1:0] b_re;
  logic signed [DATA_WIDTH-1:0] b_im;

  modport source (output valid, cmd, a_re, a_im, b_re, b_im, input ready);
  modport sink (input valid, cmd, a_re, a_im, b_re, b_im, output ready);
endinterface
`default_nettype wire

@@ hdl/cau_out_if.sv @@
// Result item channel: complex result and status flags.
`timescale 1ns / 1ps
`default_nettype none
interface cau_out_if #(parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_re;
  logic signed [DATA_WIDTH-1:0] res_im;
  logic                         div_zero;
  logic                         saturated;

  modport source (output valid, res_re, res_im, div_zero, saturated, input ready);
  modport sink (input valid, res_re, res_im, div_zero, saturated, output ready);
endinterface
`default_nettype wire

@@ hdl/complex_arithmetic_unit_top.sv @@
// Complex arithmetic unit: add, sub, mul, div, conjugate and magnitude in fixed point.
// Items pass through registered stages A, B, C and D, the divider and root steps, and the output register.
// Throughput: one item per cycle; the DATA_WIDTH + 1 stage divider and root pipeline
// sets the depth, every stage holds while the output register waits.
// Reset clears the stage valid bits and the output valid; payload registers keep data.
`timescale 1ns / 1ps
`default_nettype none
module complex_arithmetic_unit_top #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cau_in_if.sink    in_ch,
  cau_out_if.source out_ch
);
  import cau_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int MW  = W + 1;
  localparam int PW  = 2 * W;
  localparam int SW  = 2 * W + 1;
  localparam int CW  = 3 * W + F;
  localparam int SQW = 2 * W + 1;
  localparam int NS  = W + 1;

  typedef struct packed {
    logic         sat;
    logic [W-1:0] val;
  } clamp_t;

  typedef struct packed {
    cmd_t          cmd;
    logic          dz;
    logic          res_re_neg;
    logic [MW-1:0] res_re_mag;
    logic          res_im_neg;
    logic [MW-1:0] res_im_mag;
    logic [PW-1:0] den;
    logic [CW-1:0] rem_re;
    logic [CW-1:0] rem_im;
    logic          neg_re;
    logic          neg_im;
    logic          ovf_re;
    logic          ovf_im;
    logic [W-1:0]  q_re;
    logic [W-1:0]  q_im;
    logic [SQW-1:0] sq_rem;
    logic [W-1:0]  sq_root;
  } step_t;

  function automatic clamp_t clamp_sm(input logic neg, input logic [MW-1:0] mag);
    clamp_t r;
    logic [MW-1:0] lim;
    lim = MW'(1) << (W - 1);
    r.sat = 1'b0;
    if (neg) begin
      if (mag > lim) begin
        r.sat = 1'b1;
        r.val = lim[W-1:0];
      end else begin
        r.val = W'(-mag);
      end
    end else begin
      if (mag > lim - MW'(1)) begin
        r.sat = 1'b1;
        r.val = W'(lim - MW'(1));
      end else begin
        r.val = mag[W-1:0];
      end
    end
    return r;
  endfunction

  logic adv;
  logic acc;
  logic out_valid_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign acc         = in_ch.valid && adv;

  // stage A: simple ops and multiplier operand select
  cmd_t in_cmd;
  logic signed [MW-1:0] s_re;
  logic signed [MW-1:0] s_im;

  assign in_cmd = cmd_t'(in_ch.cmd);

  always_comb begin
    s_re = '0;
    s_im = '0;
    case (in_cmd)
      CMD_ADD: begin
        s_re = MW'(in_ch.a_re) + MW'(in_ch.b_re);
        s_im = MW'(in_ch.a_im) + MW'(in_ch.b_im);
      end
      CMD_SUB: begin
        s_re = MW'(in_ch.a_re) - MW'(in_ch.b_re);
        s_im = MW'(in_ch.a_im) - MW'(in_ch.b_im);
      end
      CMD_CONJ: begin
        s_re = MW'(in_ch.a_re);
        s_im = -MW'(in_ch.a_im);
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
  end

  logic                 a_v_r;
  cmd_t                 a_cmd_r;
  logic signed [W-1:0]  a_ar_r, a_ai_r, a_br_r, a_bi_r, a_y0_r, a_y1_r;
  logic                 a_re_neg_r, a_im_neg_r;
  logic [MW-1:0]        a_re_mag_r, a_im_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_cmd_r    <= in_cmd;
      a_ar_r     <= in_ch.a_re;
      a_ai_r     <= in_ch.a_im;
      a_br_r     <= in_ch.b_re;
      a_bi_r     <= in_ch.b_im;
      a_y0_r     <= (in_cmd == CMD_MAG) ? in_ch.a_re : in_ch.b_re;
      a_y1_r     <= (in_cmd == CMD_MAG) ? in_ch.a_im : in_ch.b_im;
      a_re_neg_r <= s_re[MW-1];
      a_re_mag_r <= s_re[MW-1] ? MW'(-s_re) : MW'(s_re);
      a_im_neg_r <= s_im[MW-1];
      a_im_mag_r <= s_im[MW-1] ? MW'(-s_im) : MW'(s_im);
    end
  end

  // stage B: products
  logic                 b_v_r;
  cmd_t                 b_cmd_r;
  logic signed [PW-1:0] b_p0_r, b_p1_r, b_p2_r, b_p3_r, b_p4_r, b_p5_r;
  logic                 b_re_neg_r, b_im_neg_r;
  logic [MW-1:0]        b_re_mag_r, b_im_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_cmd_r    <= a_cmd_r;
      b_p0_r     <= PW'(a_ar_r) * PW'(a_y0_r);
      b_p1_r     <= PW'(a_ai_r) * PW'(a_y1_r);
      b_p2_r     <= PW'(a_ai_r) * PW'(a_br_r);
      b_p3_r     <= PW'(a_ar_r) * PW'(a_bi_r);
      b_p4_r     <= PW'(a_br_r) * PW'(a_br_r);
      b_p5_r     <= PW'(a_bi_r) * PW'(a_bi_r);
      b_re_neg_r <= a_re_neg_r;
      b_re_mag_r <= a_re_mag_r;
      b_im_neg_r <= a_im_neg_r;
      b_im_mag_r <= a_im_mag_r;
    end
  end

  // stage C: sums
  logic                 c_v_r;
  cmd_t                 c_cmd_r;
  logic signed [SW-1:0] c_re_r, c_im_r;
  logic [PW-1:0]        c_den_r;
  logic                 c_re_neg_r, c_im_neg_r;
  logic [MW-1:0]        c_re_mag_r, c_im_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (adv) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_cmd_r    <= b_cmd_r;
      c_re_r     <= (b_cmd_r == CMD_MUL) ? SW'(b_p0_r) - SW'(b_p1_r)
                                         : SW'(b_p0_r) + SW'(b_p1_r);
      c_im_r     <= (b_cmd_r == CMD_MUL) ? SW'(b_p2_r) + SW'(b_p3_r)
                                         : SW'(b_p2_r) - SW'(b_p3_r);
      c_den_r    <= $unsigned(b_p4_r) + $unsigned(b_p5_r);
      c_re_neg_r <= b_re_neg_r;
      c_re_mag_r <= b_re_mag_r;
      c_im_neg_r <= b_im_neg_r;
      c_im_mag_r <= b_im_mag_r;
    end
  end

  // stage D: magnitudes, product scaling, divider and root setup
  logic          d_re_neg, d_im_neg;
  logic [PW-1:0] d_re_mag, d_im_mag;
  logic [PW-1:0] d_mre, d_mim;
  step_t         d_nxt;

  always_comb begin
    d_re_neg = c_re_r[SW-1];
    d_im_neg = c_im_r[SW-1];
    d_re_mag = d_re_neg ? PW'(-c_re_r) : PW'(c_re_r);
    d_im_mag = d_im_neg ? PW'(-c_im_r) : PW'(c_im_r);
    d_mre    = d_re_mag >> F;
    d_mim    = d_im_mag >> F;

    d_nxt            = '0;
    d_nxt.cmd        = c_cmd_r;
    d_nxt.dz         = (c_den_r == '0);
    d_nxt.den        = c_den_r;
    d_nxt.rem_re     = CW'(d_re_mag) << F;
    d_nxt.rem_im     = CW'(d_im_mag) << F;
    d_nxt.neg_re     = d_re_neg;
    d_nxt.neg_im     = d_im_neg;
    d_nxt.sq_rem     = SQW'(c_re_r);
    d_nxt.res_re_neg = c_re_neg_r;
    d_nxt.res_re_mag = c_re_mag_r;
    d_nxt.res_im_neg = c_im_neg_r;
    d_nxt.res_im_mag = c_im_mag_r;
    if (c_cmd_r == CMD_MUL) begin
      d_nxt.res_re_neg = d_re_neg;
      d_nxt.res_im_neg = d_im_neg;
      d_nxt.res_re_mag = ((d_mre >> W) != '0) ? {1'b1, {W{1'b0}}} : MW'(d_mre);
      d_nxt.res_im_mag = ((d_mim >> W) != '0) ? {1'b1, {W{1'b0}}} : MW'(d_mim);
    end
  end

  logic [NS:0] sv_r;
  step_t       st_r [0:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else if (adv) begin
      sv_r <= {sv_r[NS-1:0], c_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= d_nxt;
    end
  end

  // divider and root steps: the first sets the overflow flags, each later one gives one quotient bit and one root bit
  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam int I = W - k;
    step_t         nxt;
    logic [CW-1:0] dsh;
    logic          bre, bim;

    assign dsh = CW'(st_r[k].den) << I;
    assign bre = (st_r[k].rem_re >= dsh);
    assign bim = (st_r[k].rem_im >= dsh);

    if (k == 0) begin : g_ovf
      always_comb begin
        nxt        = st_r[k];
        nxt.ovf_re = bre;
        nxt.ovf_im = bim;
        if (bre) begin
          nxt.rem_re = st_r[k].rem_re - dsh;
        end
        if (bim) begin
          nxt.rem_im = st_r[k].rem_im - dsh;
        end
      end
    end else begin : g_bit
      logic [SQW-1:0] trial;
      assign trial = (SQW'(st_r[k].sq_root) << (I + 1)) + (SQW'(1) << (2 * I));
      always_comb begin
        nxt          = st_r[k];
        nxt.q_re[I]  = bre;
        nxt.q_im[I]  = bim;
        if (bre) begin
          nxt.rem_re = st_r[k].rem_re - dsh;
        end
        if (bim) begin
          nxt.rem_im = st_r[k].rem_im - dsh;
        end
        if (st_r[k].sq_rem >= trial) begin
          nxt.sq_rem     = st_r[k].sq_rem - trial;
          nxt.sq_root[I] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k+1] <= nxt;
      end
    end
  end

  // final stage: clamp and select
  step_t         fin;
  logic [MW-1:0] qm_re, qm_im;
  clamp_t        cl_re, cl_im;
  logic [W-1:0]  res_re_nxt, res_im_nxt;
  logic          dz_nxt, sat_nxt;

  assign fin = st_r[NS];

  always_comb begin
    qm_re = fin.ovf_re ? {1'b1, {W{1'b0}}} : {1'b0, fin.q_re};
    qm_im = fin.ovf_im ? {1'b1, {W{1'b0}}} : {1'b0, fin.q_im};
    cl_re = clamp_sm(fin.res_re_neg, fin.res_re_mag);
    cl_im = clamp_sm(fin.res_im_neg, fin.res_im_mag);
    res_re_nxt = '0;
    res_im_nxt = '0;
    dz_nxt     = 1'b0;
    sat_nxt    = 1'b0;
    case (fin.cmd)
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_CONJ: begin
        res_re_nxt = cl_re.val;
        res_im_nxt = cl_im.val;
        sat_nxt    = cl_re.sat || cl_im.sat;
      end
      CMD_DIV: begin
        if (fin.dz) begin
          dz_nxt = 1'b1;
        end else begin
          cl_re      = clamp_sm(fin.neg_re && (qm_re != '0), qm_re);
          cl_im      = clamp_sm(fin.neg_im && (qm_im != '0), qm_im);
          res_re_nxt = cl_re.val;
          res_im_nxt = cl_im.val;
          sat_nxt    = cl_re.sat || cl_im.sat;
        end
      end
      CMD_MAG: begin
        cl_re      = clamp_sm(1'b0, {1'b0, fin.sq_root});
        res_re_nxt = cl_re.val;
        sat_nxt    = cl_re.sat;
      end
      default: begin
        res_re_nxt = '0;
        res_im_nxt = '0;
      end
    endcase
  end

  logic [W-1:0] res_re_r, res_im_r;
  logic         dz_r, sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sv_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      dz_r     <= dz_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.res_re    = res_re_r;
  assign out_ch.res_im    = res_im_r;
  assign out_ch.div_zero  = dz_r;
  assign out_ch.saturated = sat_r;
endmodule
`default_nettype wire
